// ===== sv/sytcd_pkg.sv =====
// Shared types, constants and tables for the seconds-of-year to calendar date block.
`default_nettype none

package sytcd_pkg;

    localparam int YEAR_W      = 14;
    localparam int SECS_W      = 25;
    localparam int DAYS_W      = 9;
    localparam int REM_W       = 17;
    localparam int REM2_W      = 12;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int MON_W       = 4;
    localparam int DAY_W       = 6;
    localparam int WDAY_W      = 3;
    localparam int J_W         = 23;
    localparam int C_W         = 8;
    localparam int F7_W        = 17;
    localparam int F3_W        = 9;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam int MONTHS      = 12;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_WEEK = 7;

    // floor(x / 86400) = floor((x >> 7) * DAY_RECIP >> DAY_K), exact over 25 bits
    localparam int DAY_SHIFT   = 7;
    localparam int DAY_RECIP   = 397683;
    localparam int DAY_K       = 28;
    localparam int DAY_PROD_W  = 37;

    // floor(y / 25), exact over 14 bits
    localparam int Y25_RECIP   = 41944;
    localparam int Y25_K       = 20;
    localparam int Y25_PROD_W  = 30;
    localparam int Q25_W       = 10;

    // floor(r / 3600) = floor((r >> 4) / 225)
    localparam int HOUR_SHIFT  = 4;
    localparam int HOUR_RECIP  = 9321;
    localparam int HOUR_K      = 21;
    localparam int HOUR_PROD_W = 27;

    // floor(t / 100) = floor((t >> 2) / 25)
    localparam int C100_SHIFT  = 2;
    localparam int C100_RECIP  = 5243;
    localparam int C100_K      = 17;
    localparam int C100_PROD_W = 25;

    // floor(r / 60) = floor((r >> 2) / 15)
    localparam int MIN_SHIFT   = 2;
    localparam int MIN_RECIP   = 1093;
    localparam int MIN_K       = 14;
    localparam int MIN_PROD_W  = 21;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic              leap;
        logic [DAYS_W-1:0] days;
        logic [REM_W-1:0]  rem;
    } sytcd_item_t;

    function automatic logic [DAYS_W-1:0] month_first_day(input logic leap,
                                                          input logic [MON_W-1:0] idx);
        logic [DAYS_W-1:0] base;
        begin
            unique case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd365;
            endcase
            month_first_day = base + DAYS_W'(leap && (idx >= 4'd2));
        end
    endfunction

    // floor(275 * (idx + 1) / 9)
    function automatic logic [DAYS_W-1:0] month_term(input logic [MON_W-1:0] idx);
        begin
            unique case (idx)
                4'd0:    month_term = 9'd30;
                4'd1:    month_term = 9'd61;
                4'd2:    month_term = 9'd91;
                4'd3:    month_term = 9'd122;
                4'd4:    month_term = 9'd152;
                4'd5:    month_term = 9'd183;
                4'd6:    month_term = 9'd213;
                4'd7:    month_term = 9'd244;
                4'd8:    month_term = 9'd275;
                4'd9:    month_term = 9'd305;
                4'd10:   month_term = 9'd336;
                default: month_term = 9'd366;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/sytcd_front.sv =====
// Front end: accept requests, split off the day of year and classify the year as leap or common.
`default_nettype none

module sytcd_front
    import sytcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [YEAR_W-1:0] in_year,
    input  logic [SECS_W-1:0] in_secs,
    output logic              out_valid,
    input  logic              out_ready,
    output sytcd_item_t       out_item
);

    logic              v0_reg, v1_reg, v2_reg;
    logic              rdy0, rdy1, rdy2;

    logic [YEAR_W-1:0] year0_reg;
    logic [SECS_W-1:0] secs0_reg;

    logic [YEAR_W-1:0] year1_reg;
    logic [SECS_W-1:0] secs1_reg;
    logic [DAYS_W-1:0] days1_reg;
    logic [Q25_W-1:0]  q25_1_reg;

    sytcd_item_t       item2_reg;

    logic [DAY_PROD_W-1:0] day_prod;
    logic [Y25_PROD_W-1:0] y25_prod;
    logic [DAYS_W-1:0]     days1_next;
    logic [Q25_W-1:0]      q25_1_next;

    logic [SECS_W-1:0]     day_secs;
    logic [SECS_W-1:0]     rem_full;
    logic [YEAR_W-1:0]     q25_x25;
    logic                  div25;
    sytcd_item_t           item2_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

    always_comb
    begin
        day_prod   = DAY_PROD_W'(secs0_reg[SECS_W-1:DAY_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
        days1_next = day_prod[DAY_K +: DAYS_W];
        y25_prod   = Y25_PROD_W'(year0_reg) * Y25_PROD_W'(Y25_RECIP);
        q25_1_next = y25_prod[Y25_K +: Q25_W];
    end

    always_comb
    begin
        day_secs   = SECS_W'(days1_reg) * SECS_W'(SECS_PER_DAY);
        rem_full   = secs1_reg - day_secs;
        q25_x25    = YEAR_W'(q25_1_reg) * YEAR_W'(25);
        div25      = (q25_x25 == year1_reg);
        item2_next.year = year1_reg;
        item2_next.leap = (year1_reg[1:0] == 2'd0) && (!div25 || (year1_reg[3:0] == 4'd0));
        item2_next.days = days1_reg;
        item2_next.rem  = rem_full[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            year0_reg <= in_year;
            secs0_reg <= in_secs;
        end
        if (rdy1 && v0_reg)
        begin
            year1_reg <= year0_reg;
            secs1_reg <= secs0_reg;
            days1_reg <= days1_next;
            q25_1_reg <= q25_1_next;
        end
        if (rdy2 && v1_reg)
        begin
            item2_reg <= item2_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sytcd_queue.sv =====
// Short queue that decouples the front end from the back end.
`default_nettype none

module sytcd_queue
    import sytcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sytcd_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output sytcd_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sytcd_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sytcd_back.sv =====
// Back end: time of day, month lookup, day of month and weekday, ending in the output register.
`default_nettype none

module sytcd_back
    import sytcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sytcd_item_t       in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SEC_W-1:0]  sec_of_minute,
    output logic [MIN_W-1:0]  min_of_hour,
    output logic [HOUR_W-1:0] hour_of_day,
    output logic [MON_W-1:0]  month_index,
    output logic [DAY_W-1:0]  day_of_month,
    output logic [WDAY_W-1:0] weekday,
    output logic              past_year_end
);

    function automatic logic [WDAY_W-1:0] wday_mod7(input logic [J_W-1:0] j);
        logic [5:0] s1;
        logic [3:0] s2;
        begin
            s1 = 6'(j[J_W-1:21]);
            for (int i = 0; i < 7; i++)
            begin
                s1 = s1 + 6'(j[3*i +: 3]);
            end
            s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
            if (s2 >= 4'(DAYS_PER_WEEK))
            begin
                s2 = s2 - 4'(DAYS_PER_WEEK);
            end
            wday_mod7 = s2[WDAY_W-1:0];
        end
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1
    logic [YEAR_W-1:0] year1_reg;
    logic              leap1_reg;
    logic [DAYS_W-1:0] days1_reg;
    logic [REM_W-1:0]  rem1_reg;
    logic [HOUR_W-1:0] hour1_reg, hour1_next;
    logic [MON_W-1:0]  mon1_reg, mon1_next;
    logic              past1_reg, past1_next;
    logic [HOUR_PROD_W-1:0] hour_prod;

    // stage 2
    logic [REM2_W-1:0] rem2_reg, rem2_next;
    logic [HOUR_W-1:0] hour2_reg;
    logic [MON_W-1:0]  mon2_reg;
    logic [DAY_W-1:0]  day2_reg, day2_next;
    logic              past2_reg;
    logic [J_W-1:0]    y367_2_reg, y367_2_next;
    logic [F7_W-1:0]   f7_2_reg, f7_2_next;
    logic [C_W-1:0]    c2_reg, c2_next;
    logic [REM_W-1:0]  hour_secs;
    logic [REM_W-1:0]  rem2_full;
    logic [DAYS_W-1:0] day_full;
    logic              early;
    logic [YEAR_W-1:0] t_year;
    logic [C100_PROD_W-1:0] c_prod;

    // stage 3
    logic [REM2_W-1:0] rem3_reg;
    logic [MIN_W-1:0]  min3_reg, min3_next;
    logic [HOUR_W-1:0] hour3_reg;
    logic [MON_W-1:0]  mon3_reg;
    logic [DAY_W-1:0]  day3_reg;
    logic              past3_reg;
    logic [J_W-1:0]    j3_reg, j3_next;
    logic [MIN_PROD_W-1:0] min_prod;
    logic [F3_W-1:0]   f3_full;

    // stage 4 (output register)
    logic [SEC_W-1:0]  sec4_reg, sec4_next;
    logic [MIN_W-1:0]  min4_reg;
    logic [HOUR_W-1:0] hour4_reg;
    logic [MON_W-1:0]  mon4_reg;
    logic [DAY_W-1:0]  day4_reg;
    logic [WDAY_W-1:0] wday4_reg, wday4_next;
    logic              past4_reg;
    logic [REM2_W-1:0] min_secs;
    logic [REM2_W-1:0] sec_full;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign out_valid     = v4_reg;
    assign sec_of_minute = sec4_reg;
    assign min_of_hour   = min4_reg;
    assign hour_of_day   = hour4_reg;
    assign month_index   = mon4_reg;
    assign day_of_month  = day4_reg;
    assign weekday       = wday4_reg;
    assign past_year_end = past4_reg;

    always_comb
    begin
        hour_prod  = HOUR_PROD_W'(in_item.rem[REM_W-1:HOUR_SHIFT]) * HOUR_PROD_W'(HOUR_RECIP);
        hour1_next = hour_prod[HOUR_K +: HOUR_W];
        mon1_next  = '0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (in_item.days >= month_first_day(in_item.leap, MON_W'(i)))
            begin
                mon1_next = mon1_next + 1'b1;
            end
        end
        past1_next = (in_item.days >= month_first_day(in_item.leap, MON_W'(MONTHS)));
    end

    always_comb
    begin
        hour_secs   = REM_W'(hour1_reg) * REM_W'(SECS_PER_HOUR);
        rem2_full   = rem1_reg - hour_secs;
        rem2_next   = rem2_full[REM2_W-1:0];
        day_full    = days1_reg - month_first_day(leap1_reg, mon1_reg) + 1'b1;
        day2_next   = day_full[DAY_W-1:0];
        early       = (mon1_reg < 4'd2);
        if (!early)
        begin
            t_year = year1_reg;
        end
        else if (year1_reg == '0)
        begin
            t_year = '0;
        end
        else
        begin
            t_year = year1_reg - 1'b1;
        end
        c_prod      = C100_PROD_W'(t_year[YEAR_W-1:C100_SHIFT]) * C100_PROD_W'(C100_RECIP);
        c2_next     = c_prod[C100_K +: C_W];
        y367_2_next = J_W'(year1_reg) * J_W'(367);
        f7_2_next   = (F7_W'(year1_reg) + F7_W'(!early)) * F7_W'(7);
    end

    always_comb
    begin
        min_prod  = MIN_PROD_W'(rem2_reg[REM2_W-1:MIN_SHIFT]) * MIN_PROD_W'(MIN_RECIP);
        min3_next = min_prod[MIN_K +: MIN_W];
        f3_full   = (F3_W'(c2_reg) + 1'b1) * F3_W'(3);
        j3_next   = y367_2_reg
                  - J_W'(f7_2_reg[F7_W-1:2])
                  - J_W'(f3_full[F3_W-1:2])
                  + J_W'(month_term(mon2_reg))
                  + J_W'(day2_reg)
                  + J_W'(3);
    end

    always_comb
    begin
        min_secs   = REM2_W'(min3_reg) * REM2_W'(SECS_PER_MIN);
        sec_full   = rem3_reg - min_secs;
        sec4_next  = sec_full[SEC_W-1:0];
        wday4_next = wday_mod7(j3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            year1_reg <= in_item.year;
            leap1_reg <= in_item.leap;
            days1_reg <= in_item.days;
            rem1_reg  <= in_item.rem;
            hour1_reg <= hour1_next;
            mon1_reg  <= mon1_next;
            past1_reg <= past1_next;
        end
        if (rdy2 && v1_reg)
        begin
            rem2_reg   <= rem2_next;
            hour2_reg  <= hour1_reg;
            mon2_reg   <= mon1_reg;
            day2_reg   <= day2_next;
            past2_reg  <= past1_reg;
            y367_2_reg <= y367_2_next;
            f7_2_reg   <= f7_2_next;
            c2_reg     <= c2_next;
        end
        if (rdy3 && v2_reg)
        begin
            rem3_reg  <= rem2_reg;
            min3_reg  <= min3_next;
            hour3_reg <= hour2_reg;
            mon3_reg  <= mon2_reg;
            day3_reg  <= day2_reg;
            past3_reg <= past2_reg;
            j3_reg    <= j3_next;
        end
        if (rdy4 && v3_reg)
        begin
            sec4_reg  <= sec4_next;
            min4_reg  <= min3_reg;
            hour4_reg <= hour3_reg;
            mon4_reg  <= mon3_reg;
            day4_reg  <= day3_reg;
            wday4_reg <= wday4_next;
            past4_reg <= past3_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sv/seconds_of_year_to_calendar_date.sv =====
// Top level: seconds of year to calendar date with weekday, on stream ports.
// Request path: 3 front, 1 queue and 4 back register stages lie between the edge that accepts a
// request and its result on m_axis.
// Throughput: one request per cycle; every stage is a pipeline register and divisions by
// constants use reciprocal multiplies. Stalls come only from m_axis back-pressure.
// Reset clears stage valid flags, queue pointers and queue count only; no clearing pass is needed.
`default_nettype none

module seconds_of_year_to_calendar_date
    import sytcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // year[13:0], seconds_in_year[38:14]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sec_of_minute[5:0], min_of_hour[11:6],
                                                  // hour_of_day[16:12], month_index[20:17],
                                                  // day_of_month[26:21], weekday[29:27]
    output logic                   m_axis_tuser   // past_year_end
);

    logic              fr_valid, fr_ready;
    sytcd_item_t       fr_item;
    logic              q_valid, q_ready;
    sytcd_item_t       q_item;

    logic [SEC_W-1:0]  sec_of_minute;
    logic [MIN_W-1:0]  min_of_hour;
    logic [HOUR_W-1:0] hour_of_day;
    logic [MON_W-1:0]  month_index;
    logic [DAY_W-1:0]  day_of_month;
    logic [WDAY_W-1:0] weekday;
    logic              past_year_end;

    sytcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_year   (s_axis_tdata[YEAR_W-1:0]),
        .in_secs   (s_axis_tdata[YEAR_W +: SECS_W]),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    sytcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    sytcd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .sec_of_minute (sec_of_minute),
        .min_of_hour   (min_of_hour),
        .hour_of_day   (hour_of_day),
        .month_index   (month_index),
        .day_of_month  (day_of_month),
        .weekday       (weekday),
        .past_year_end (past_year_end)
    );

    assign m_axis_tdata = {2'b00, weekday, day_of_month, month_index,
                           hour_of_day, min_of_hour, sec_of_minute};
    assign m_axis_tuser = past_year_end;

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (hour_of_day <= 5'd23) && (min_of_hour <= 6'd59)
                          && (sec_of_minute <= 6'd59) && (weekday <= 3'd6))
        else $error("time of day or weekday out of range");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (month_index <= 4'd11) && (day_of_month != 6'd0))
        else $error("month or day of month out of range");

    a_in_year_day: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !past_year_end) |-> (day_of_month <= 6'd31))
        else $error("day of month past 31 inside the year");

    a_past_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && past_year_end) |-> (month_index == 4'd11))
        else $error("past year end outside December");

endmodule

`default_nettype wire

// ===== tb/sv/seconds_of_year_to_calendar_date_tb.sv =====
// Self-checking testbench for the seconds-of-year to calendar date stream block.
`default_nettype none

module seconds_of_year_to_calendar_date_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sytcd_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_OFF_SPAN  = 200;
    localparam int MAX_SECONDS    = 33554431;
    localparam int MAX_YEAR       = 16383;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        bit [5:0] sec;
        bit [5:0] min;
        bit [4:0] hour;
        bit [3:0] month;
        bit [5:0] day;
        bit [2:0] wday;
        bit       past;
    } date_fields_t;

    class date_scoreboard;
        date_fields_t pending_dates[$];
        int failures;

        function date_fields_t calendar_of(bit [13:0] year, bit [24:0] secs);
            date_fields_t r;
            int unsigned days;
            int unsigned first_day;
            int unsigned mon;
            int unsigned lengths[12];
            bit leap;
            longint y, m, a, b, t, c, dm, j;
            lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            leap = (year[1:0] == 2'b00) && ((year % 100) != 0 || (year % 400) == 0);
            if (leap)
            begin
                lengths[1] = 29;
            end
            days = secs / 86400;
            r.sec = 6'(secs % 60);
            r.min = 6'((secs / 60) % 60);
            r.hour = 5'((secs / 3600) % 24);
            first_day = 0;
            mon = 0;
            while (mon < 11 && days >= first_day + lengths[mon])
            begin
                first_day += lengths[mon];
                mon++;
            end
            r.month = 4'(mon);
            r.day = 6'(days - first_day + 1);
            r.past = (days >= (leap ? 366 : 365));
            // day number from the 1-based month; century term clamps at zero
            y = longint'(year);
            m = longint'(mon) + 1;
            a = (m >= 3) ? 1 : 0;
            b = (m <= 2) ? -1 : 0;
            t = y + b;
            c = (t < 0) ? 0 : t / 100;
            dm = longint'(r.day);
            j = 367 * y - (7 * (y + a)) / 4 - (3 * (c + 1)) / 4 + (275 * m) / 9 + dm + 3;
            if (j < 0)
            begin
                j = 0;
            end
            r.wday = 3'(j % 7);
            return r;
        endfunction

        function void note_request(bit [13:0] year, bit [24:0] secs);
            pending_dates.push_back(calendar_of(year, secs));
        endfunction

        function void check_result(bit [OUT_TDATA_W-1:0] data, bit user);
            date_fields_t want;
            date_fields_t got;
            got.sec   = data[5:0];
            got.min   = data[11:6];
            got.hour  = data[16:12];
            got.month = data[20:17];
            got.day   = data[26:21];
            got.wday  = data[29:27];
            got.past  = user;
            if (pending_dates.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("unexpected result: tdata=%h tuser=%0d", data, user);
                end
                return;
            end
            want = pending_dates.pop_front();
            if (want != got)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("mismatch: expected %0d:%0d:%0d mon=%0d day=%0d wd=%0d past=%0d",
                             want.hour, want.min, want.sec, want.month, want.day,
                             want.wday, want.past);
                    $display("          actual   %0d:%0d:%0d mon=%0d day=%0d wd=%0d past=%0d",
                             got.hour, got.min, got.sec, got.month, got.day,
                             got.wday, got.past);
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    date_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_off_req;
    int cycles;

    seconds_of_year_to_calendar_date u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // receiver: random back-pressure, or a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_SPAN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input bit [13:0] year, input bit [24:0] secs);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, secs, year};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_request(year, secs);
    endtask

    task automatic stop_and_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_request(output bit [13:0] year, output bit [24:0] secs);
        int unsigned roll;
        int unsigned day;
        int unsigned month_firsts[26];
        month_firsts = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365,
                         60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366, 1, 58};
        roll = $urandom_range(99);
        if (roll < 70)
            year = 14'($urandom_range(9999, 1));
        else if (roll < 80)
            year = 14'(100 * $urandom_range(99, 0));
        else if (roll < 88)
            year = 14'($urandom_range(3, 0));
        else
            year = 14'($urandom_range(MAX_YEAR, 10000));
        roll = $urandom_range(99);
        if (roll < 75)
        begin
            day = $urandom_range(365);
            secs = 25'(day * 86400 + $urandom_range(86399));
        end
        else if (roll < 90)
        begin
            day = month_firsts[$urandom_range(25)];
            if (day > 0 && $urandom_range(1))
                secs = 25'(day * 86400 - 1 - $urandom_range(2));
            else
                secs = 25'(day * 86400 + $urandom_range(2));
        end
        else
        begin
            secs = 25'($urandom_range(MAX_SECONDS));
        end
    endtask

    task automatic send_random(input int count);
        bit [13:0] year;
        bit [24:0] secs;
        repeat (count)
        begin
            random_request(year, secs);
            send_request(year, secs);
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        hold_off_req = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 81;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // boundaries: year ends, leap rules, year zero, widest fields
        send_request(14'd1, 25'd0);
        send_request(14'd9999, 25'd31535999);
        send_request(14'd2000, 25'd31622399);
        send_request(14'd1900, 25'd31535999);
        send_request(14'd1900, 25'd31536000);
        send_request(14'd2024, 25'd5097600);
        send_request(14'd2023, 25'd5097600);
        send_request(14'd2024, 25'd5097599);
        send_request(14'd0, 25'd0);
        send_request(14'd0, 25'd3456000);
        send_request(14'd0, 25'd5184000);
        send_request(14'd16383, 25'd33554431);
        send_request(14'd2000, 25'd31622400);
        send_request(14'd8192, 25'd16777216);
        send_request(14'd4, 25'd86399);
        send_request(14'd100, 25'd31536000);
        send_request(14'd400, 25'd31622400);
        send_request(14'd2023, 25'd28857600);
        send_request(14'd9999, 25'd33554431);
        send_request(14'd1, 25'd31535999);
        send_random(180);
        stop_and_drain();

        send_idle_pct = 81;
        recv_idle_pct = 31;
        send_random(180);
        stop_and_drain();

        // hold the output off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
        send_random(40);
        send_random(150);
        stop_and_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending_dates.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
